[rtl/core/mau_pkg.sv]
// Shared types and constants for the modular arithmetic unit.
package mau_pkg;
    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_POW = 3'd4, OP_NEG = 3'd5, OP_RED = 3'd6, OP_EQU = 3'd7
    } t_op;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
endpackage

[rtl/core/mau_divider.sv]
// Restoring bit-serial divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
module mau_divider
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient,
    output logic [31:0] o_remainder
);
    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;
    logic [33:0] n_diff;

    assign n_shift = {r_rem[31:0], r_quo[63]};
    assign n_diff  = {1'b0, n_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (!n_diff[33]) begin
                    r_rem <= n_diff[32:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[31:0];
endmodule

[rtl/core/mau_sequencer.sv]
// Sequencer: reduction, add, subtract, multiply, negate, compare, power and extended Euclid over a shared divider.
module mau_sequencer
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [31:0] i_mod,
    output logic        o_done,
    output logic [31:0] o_result,
    output logic        o_is_equal,
    output logic        o_error
);
    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RB, S_DISP, S_MUL, S_EU, S_EUMUL, S_EUMOD, S_INV,
        S_PSQ, S_DONE
    } t_state;

    t_state      r_state, r_ret;
    t_op         r_op;
    logic [63:0] r_b_raw;
    logic [31:0] r_m, r_a, r_b, r_acc, r_res;
    logic        r_eq, r_err;
    // Euclid: x1,y1 fit 32 bits; x2,y2 bounded by m in magnitude
    logic [31:0] r_x1, r_y1;
    logic signed [33:0] r_x2, r_y2;
    logic signed [33:0] r_prod;
    logic [63:0] r_exp;
    logic [1:0]  r_psel;
    logic        r_neg;

    logic        d_start, d_done;
    logic [63:0] d_dividend, d_quo;
    logic [31:0] d_divisor, d_rem;
    logic [31:0] n_fix;

    mau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_dividend(d_dividend), .i_divisor(d_divisor),
        .o_done(d_done), .o_quotient(d_quo), .o_remainder(d_rem)
    );

    // negative operands wrap up: m - r unless r is zero
    assign n_fix = (r_neg && d_rem != 32'd0) ? r_m - d_rem : d_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            d_start <= 1'b0;
        end else begin
            d_start <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_op       <= t_op'(i_operation);
                    r_b_raw    <= i_operand_b;
                    r_m        <= (i_mod == 32'd0) ? 32'd1 : i_mod;
                    r_neg      <= i_operand_a[63];
                    d_dividend <= i_operand_a[63] ? (~i_operand_a + 64'd1) : i_operand_a;
                    d_divisor  <= (i_mod == 32'd0) ? 32'd1 : i_mod;
                    d_start    <= 1'b1;
                    r_eq       <= 1'b0;
                    r_err      <= 1'b0;
                    r_state    <= S_RA;
                end
                S_RA: if (d_done) begin
                    r_a        <= n_fix;
                    r_neg      <= r_b_raw[63];
                    d_dividend <= r_b_raw[63] ? (~r_b_raw + 64'd1) : r_b_raw;
                    d_start    <= 1'b1;
                    r_state    <= S_RB;
                end
                S_RB: if (d_done) begin
                    r_b     <= n_fix;
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_neg   <= 1'b0;
                    unique case (r_op)
                        OP_ADD: begin
                            d_dividend <= {31'd0, {1'b0, r_a} + {1'b0, r_b}};
                            d_start <= 1'b1; r_ret <= S_DONE; r_state <= S_MUL;
                        end
                        OP_SUB: begin
                            d_dividend <= {31'd0, {1'b0, r_a} + {1'b0, r_m} - {1'b0, r_b}};
                            d_start <= 1'b1; r_ret <= S_DONE; r_state <= S_MUL;
                        end
                        OP_MUL: begin
                            d_dividend <= {32'd0, r_a} * {32'd0, r_b};
                            d_start <= 1'b1; r_ret <= S_DONE; r_state <= S_MUL;
                        end
                        OP_NEG: begin
                            d_dividend <= {32'd0, r_m - r_a};
                            d_start <= 1'b1; r_ret <= S_DONE; r_state <= S_MUL;
                        end
                        OP_RED: begin
                            r_res <= r_a; r_state <= S_DONE;
                        end
                        OP_EQU: begin
                            r_res <= 32'd0; r_eq <= (r_a == r_b); r_state <= S_DONE;
                        end
                        OP_DIV: begin
                            r_x1 <= r_b; r_y1 <= r_m;
                            r_x2 <= 34'sd1; r_y2 <= 34'sd0;
                            r_state <= S_EU;
                        end
                        OP_POW: begin
                            // 1 mod m, then square-and-multiply
                            d_dividend <= 64'd1;
                            d_start <= 1'b1;
                            r_exp <= r_b_raw[63] ? 64'd0 : r_b_raw;
                            r_psel <= 2'd0; r_ret <= S_PSQ; r_state <= S_MUL;
                        end
                        default: begin
                            r_res <= 32'd0; r_state <= S_DONE;
                        end
                    endcase
                end
                S_MUL: if (d_done) begin
                    r_res   <= d_rem;
                    r_state <= r_ret;
                end
                S_PSQ: begin
                    // r_psel: 0 acc from 1%m, 1 acc from multiply, 2 base from square
                    if (r_psel == 2'd0) begin
                        r_acc <= r_res;
                    end else if (r_psel == 2'd1) begin
                        r_acc <= r_res;
                    end else begin
                        r_a <= r_res;
                        r_exp <= {1'b0, r_exp[63:1]};
                    end
                    if (r_psel == 2'd2 || r_psel == 2'd0) begin
                        if ((r_psel == 2'd0 ? r_exp : {1'b0, r_exp[63:1]}) == 64'd0) begin
                            r_res <= (r_psel == 2'd0) ? r_res : r_acc;
                            r_state <= S_DONE;
                        end else if ((r_psel == 2'd0 ? r_exp[0] : r_exp[1])) begin
                            d_dividend <= {32'd0, (r_psel == 2'd0) ? r_res : r_acc}
                                          * {32'd0, (r_psel == 2'd0) ? r_a : r_res};
                            d_start <= 1'b1; r_psel <= 2'd1; r_state <= S_MUL;
                        end else begin
                            d_dividend <= {32'd0, (r_psel == 2'd0) ? r_a : r_res}
                                          * {32'd0, (r_psel == 2'd0) ? r_a : r_res};
                            d_start <= 1'b1; r_psel <= 2'd2; r_state <= S_MUL;
                        end
                    end else begin
                        d_dividend <= {32'd0, r_a} * {32'd0, r_a};
                        d_start <= 1'b1; r_psel <= 2'd2; r_state <= S_MUL;
                    end
                end
                S_EU: begin
                    if (r_y1 == 32'd0) begin
                        r_state <= S_INV;
                    end else begin
                        d_dividend <= {32'd0, r_x1};
                        d_divisor  <= r_y1;
                        d_start    <= 1'b1;
                        r_state    <= S_EUMUL;
                    end
                end
                S_EUMUL: if (d_done) begin
                    r_x1    <= d_rem;
                    r_prod  <= 34'($signed({1'b0, d_quo[32:0]}) * r_y2);
                    r_state <= S_EUMOD;
                end
                S_EUMOD: begin
                    r_x1 <= r_y1; r_y1 <= r_x1;
                    r_x2 <= r_y2;
                    r_y2 <= r_x2 - r_prod;
                    r_state <= S_EU;
                end
                S_INV: begin
                    d_divisor <= r_m;
                    if (r_x1 != 32'd1 && !(r_m == 32'd1 && r_x1 == 32'd0)) begin
                        r_err <= 1'b1; r_res <= 32'd0; r_state <= S_DONE;
                    end else begin
                        // a * inv mod m, inv = x2 wrapped into range
                        r_op <= OP_MUL;
                        r_x1 <= 32'd0; r_y1 <= 32'd0;
                        r_b <= r_x2[33] ? (r_m + r_x2[31:0]) : r_x2[31:0];
                        r_state <= S_DISP;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && !i_start) d_divisor <= i_mod == 32'd0 ? 32'd1 : i_mod;
        end
    end

    assign o_done     = (r_state == S_DONE);
    assign o_result   = r_res;
    assign o_is_equal = r_eq;
    assign o_error    = r_err;
endmodule

[rtl/core/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit.
// One word at a time: operands are reduced by a bit-serial divider, then add/sub/mul/negate
// take one more divider pass, divide runs extended Euclid with one division per step (at most
// ~47 steps) and then one multiply pass, and power takes up to 127 multiply-mod passes. The
// result sits in an output register while the next word is taken; a word that finishes while
// that register is still full waits in the sequencer, and the input stays closed until it has
// moved across.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic signed [63:0] i_operand_a,
    input  logic signed [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result,
    output logic        o_is_equal,
    output logic        o_error
);
    logic [31:0] r_mod;
    logic        r_busy, r_ov, r_pend;
    logic        s_done, s_eq, s_err;
    logic [31:0] s_res;
    logic        w_start, w_load;

    assign o_ready = i_rst_n && !r_busy;
    assign w_start = i_valid && o_ready;
    // finished word moves out once the output register is free or being emptied
    assign w_load  = r_pend && (!r_ov || i_ready);

    mau_sequencer u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_operation(i_operation), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .i_mod(r_mod),
        .o_done(s_done), .o_result(s_res), .o_is_equal(s_eq), .o_error(s_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= MODULUS_RESET;
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) r_mod <= i_cfg_wdata;
            if (w_start) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (s_done) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_ov       <= 1'b1;
                o_result   <= s_res;
                o_is_equal <= s_eq;
                o_error    <= s_err;
            end else if (o_valid && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end
    assign o_valid = r_ov;
endmodule

[tb/mau_checker.sv]
// Result checker for the modular arithmetic unit: predicts each word and compares it.
module mau_checker
    import mau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_result,
    input  logic        o_is_equal,
    input  logic        o_error,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] result;
        logic        is_equal;
        logic        error;
    } t_residue_word;

    t_residue_word    pending_words[$];
    logic [31:0]      modulus_reg = MODULUS_RESET;
    int               mismatches = 0;

    // Two's-complement pattern folded into 0 .. m-1
    function automatic longint unsigned fold(longint unsigned bits, longint unsigned m);
        longint unsigned mag;
        longint unsigned r;
        if (!bits[63]) begin
            return bits % m;
        end
        mag = ~bits + 64'd1;
        r   = mag % m;
        return (r == 0) ? 64'd0 : m - r;
    endfunction

    function automatic t_residue_word compute_residue(logic [2:0] op_bits,
            longint unsigned a_raw, longint unsigned b_raw, logic [31:0] modulus);
        t_residue_word   w;
        longint unsigned m, a, b, acc, sq, e;
        longint          x1, y1, x2, y2, q, t;
        t_op             op;
        op = t_op'(op_bits);
        w  = '0;
        m  = (modulus == 0) ? 64'd1 : {32'd0, modulus};
        a  = fold(a_raw, m);
        b  = fold(b_raw, m);
        case (op)
            OP_ADD: w.result = 32'((a + b) % m);
            OP_SUB: w.result = 32'((a + m - b) % m);
            OP_MUL: w.result = 32'((a * b) % m);
            OP_DIV: begin
                x1 = longint'(b); y1 = longint'(m); x2 = 1; y2 = 0;
                while (y1 > 0) begin
                    q  = x1 / y1;
                    x2 = x2 - q * y2;
                    x1 = x1 % y1;
                    t = x1; x1 = y1; y1 = t;
                    t = x2; x2 = y2; y2 = t;
                end
                if (x1 != 1) begin
                    w.error = 1'b1;
                end else begin
                    w.result = 32'((a * fold(unsigned'(x2), m)) % m);
                end
            end
            OP_POW: begin
                acc = 64'd1 % m;
                sq  = a;
                e   = b_raw;
                if (!e[63]) begin
                    while (e != 0) begin
                        if (e[0]) acc = (acc * sq) % m;
                        sq = (sq * sq) % m;
                        e  = e >> 1;
                    end
                end
                w.result = 32'(acc);
            end
            OP_NEG: w.result = 32'((m - a) % m);
            OP_RED: w.result = 32'(a);
            default: w.is_equal = (a == b);
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_residue_word want;
        if (!i_rst_n) begin
            modulus_reg = MODULUS_RESET;
        end else begin
            if (i_cfg_we) modulus_reg = i_cfg_wdata;
            if (i_valid && o_ready)
                pending_words.push_back(compute_residue(i_operation, i_operand_a,
                                                        i_operand_b, modulus_reg));
            if (o_valid && i_ready) begin
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: result=%0d eq=%0b err=%0b",
                                 o_result, o_is_equal, o_error);
                end else begin
                    want = pending_words.pop_front();
                    if (want.result !== o_result || want.is_equal !== o_is_equal ||
                            want.error !== o_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word differs: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.result, want.is_equal, want.error,
                                     o_result, o_is_equal, o_error);
                    end
                end
            end
        end
        o_fail_count  = mismatches;
        o_outstanding = pending_words.size();
    end
endmodule

[tb/tb_modular_arithmetic_unit.sv]
// Stimulus, handshake timing and verdict for the modular arithmetic unit.
module tb_modular_arithmetic_unit;
    import mau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT = 60000;
    localparam logic [31:0] MODULUS_MAX = 32'd3037000499;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_operation = OP_ADD;
    logic [63:0] i_operand_a = '0;
    logic [63:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result;
    logic        o_is_equal;
    logic        o_error;
    int          fail_count, outstanding;
    int          quiet_cycles = 0;
    bit          no_gaps_tx = 0, no_gaps_rx = 0, hold_off_req = 0;

    always #10 i_clk = ~i_clk;

    modular_arithmetic_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_operation(i_operation),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b), .o_valid(o_valid),
        .i_ready(i_ready), .o_result(o_result), .o_is_equal(o_is_equal), .o_error(o_error)
    );

    mau_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_operation(i_operation),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b), .o_valid(o_valid),
        .i_ready(i_ready), .o_result(o_result), .o_is_equal(o_is_equal), .o_error(o_error),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom};
            2: return 64'($urandom_range(0, 50));
            3: return -longint'($urandom_range(1, 50));
            4: return {1'($urandom_range(0, 1)), 63'd0} - 64'($urandom_range(0, 1));
            default: return {32'd0, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_exponent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 64'($urandom_range(0, 1000));
        if (r < 85) return {1'b1, 31'($urandom), $urandom};
        return {1'b0, 31'($urandom), $urandom};
    endfunction

    task automatic send_word(t_op op, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = no_gaps_tx ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic write_modulus(logic [31:0] value);
        i_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_words(int count);
        t_op op;
        repeat (count) begin
            op = t_op'($urandom_range(0, 7));
            send_word(op, pick_operand(), (op == OP_POW) ? pick_exponent() : pick_operand());
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                i_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                i_ready <= 1'b1;
            end else if (no_gaps_rx) begin
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(20, 300)) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("modular_arithmetic_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [31:0] settings[6];
        settings = '{32'd13, 32'd12, MODULUS_MAX, 32'hFFFFFFFF, 32'd1, 32'd0};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset modulus
        send_word(OP_ADD, 64'h7FFFFFFFFFFFFFFF, 64'h7FFFFFFFFFFFFFFF);
        send_word(OP_SUB, 64'h8000000000000000, 64'hFFFFFFFFFFFFFFFF);
        send_word(OP_MUL, 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000000);
        send_word(OP_DIV, 64'd5, 64'd3);
        send_word(OP_DIV, 64'd5, 64'd0);                   // no inverse
        send_word(OP_DIV, -64'sd7, 64'd1000000007);        // divisor folds to zero
        send_word(OP_POW, 64'd2, 64'd0);
        send_word(OP_POW, 64'd2, 64'hFFFFFFFFFFFFFFFF);    // negative exponent
        send_word(OP_POW, 64'h7FFFFFFFFFFFFFFF, 64'h7FFFFFFFFFFFFFFF);
        send_word(OP_NEG, 64'd0, 64'd0);
        send_word(OP_NEG, -64'sd1, 64'd0);
        send_word(OP_RED, 64'h8000000000000000, 64'd0);
        send_word(OP_EQU, -64'sd1, 64'd1000000006);        // equal after folding
        send_word(OP_EQU, 64'd1, 64'd2);
        write_modulus(32'd12);
        send_word(OP_DIV, 64'd7, 64'd6);                   // shared factor
        send_word(OP_DIV, 64'd7, 64'd5);
        write_modulus(32'd1);
        send_word(OP_DIV, 64'd9, 64'd0);                   // inverse 0, no error
        send_word(OP_POW, 64'd9, 64'd0);
        write_modulus(32'd0);
        send_word(OP_ADD, 64'd9, 64'd4);
        send_word(OP_POW, 64'd3, 64'd0);
        write_modulus(MODULUS_MAX);
        send_word(OP_MUL, -64'sd1, -64'sd1);
        send_word(OP_DIV, 64'd1, 64'd2);

        write_modulus(MODULUS_RESET);
        no_gaps_tx = 1;
        hold_off_req = 1;
        random_words(40);
        no_gaps_tx = 0;
        foreach (settings[i]) begin
            write_modulus(settings[i]);
            no_gaps_rx = (i == 2);
            no_gaps_tx = (i == 2);
            random_words(31);
        end
        no_gaps_rx = 0;
        no_gaps_tx = 0;
        write_modulus($urandom_range(2, 100000));
        random_words(20);
        write_modulus($urandom);
        random_words(20);
        i_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("modular_arithmetic_unit: match");
        end else begin
            $display("modular_arithmetic_unit: mismatch");
        end
        $finish;
    end
endmodule
